@@ rtl/spi9_panel_register_writer_top_assert.svh @@
// assertion macros for the panel register writer
`ifndef SPI9_PANEL_REGISTER_WRITER_TOP_ASSERT_SVH
`define SPI9_PANEL_REGISTER_WRITER_TOP_ASSERT_SVH

// same-cycle implication, reset masks the check
`define SPI9_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define SPI9_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/spi9_pkg.sv @@
package spi9_pkg;

	// serial word layout
	localparam int unsigned WORD_BITS = 9;
	localparam logic [3:0] LAST_BIT_IDX = 4'(WORD_BITS - 1);
	localparam logic CMD_FLAG = 1'b0;
	localparam logic DATA_FLAG = 1'b1;

	// clock divider register
	localparam int unsigned HALF_W = 16;
	localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd600;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

endpackage

@@ rtl/spi9_panel_register_writer_top.sv @@
// each serial bit spans a low then a high half period (a zero half period setting counts as one)
// a frame is 9, 18 or 27 bits: the command word and up to two data words
// output stalls hold bits back; one frame at a time, next word taken in the cycle after its last bit is emitted
// a new word is taken while the last bit of the previous frame still waits at the output
// async reset returns to idle with the half period setting at 600
module spi9_panel_register_writer_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  reg_addr,
	input  logic [1:0]  data_count,
	input  logic [15:0] data_value,
	// output bits
	output logic        out_valid,
	input  logic        out_stall,
	output logic        sda_bit,
	output logic        word_is_data,
	output logic        frame_last
);

	spi9_pkg::state_t state_q, state_nxt;

	logic [spi9_pkg::HALF_W-1:0] half_q;
	logic [spi9_pkg::HALF_W-1:0] hp_m1;
	logic [spi9_pkg::HALF_W-1:0] cnt_q;
	logic                        phase_q;
	logic [8:0]                  shift_q;
	logic [3:0]                  bit_idx_q;
	logic [1:0]                  words_left_q;
	logic [15:0]                 pend_q;
	logic                        is_data_q;
	logic                        out_valid_q;
	logic                        sda_q;
	logic                        data_q;
	logic                        last_q;

	logic in_acc;
	logic slot_free;
	logic cnt_wrap;
	logic period_done;
	logic emit;
	logic last_bit;
	logic frame_end;

	// config register, written only while idle with no output pending
	assign cfg_ready = (state_q == spi9_pkg::ST_IDLE) && !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= spi9_pkg::HALF_PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			half_q <= cfg_data;
		end
	end

	// a zero half period setting behaves as a setting of one
	assign hp_m1 = (half_q == '0) ? '0 : half_q - 1'b1;

	// handshake and sequencing conditions
	assign in_stall    = (state_q != spi9_pkg::ST_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign slot_free   = !out_valid_q || !out_stall;
	assign cnt_wrap    = (cnt_q == hp_m1);
	assign period_done = (state_q == spi9_pkg::ST_RUN) && phase_q && cnt_wrap;
	assign last_bit    = (bit_idx_q == spi9_pkg::LAST_BIT_IDX);
	assign frame_end   = last_bit && (words_left_q == 2'd0);

	// next state and bit emit
	always_comb begin
		state_nxt = state_q;
		emit      = 1'b0;
		case (state_q)
			spi9_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_nxt = spi9_pkg::ST_RUN;
				end
			end
			spi9_pkg::ST_RUN: begin
				if (period_done) begin
					if (slot_free) begin
						emit      = 1'b1;
						state_nxt = frame_end ? spi9_pkg::ST_IDLE : spi9_pkg::ST_RUN;
					end else begin
						state_nxt = spi9_pkg::ST_HOLD;
					end
				end
			end
			spi9_pkg::ST_HOLD: begin
				if (slot_free) begin
					emit      = 1'b1;
					state_nxt = frame_end ? spi9_pkg::ST_IDLE : spi9_pkg::ST_RUN;
				end
			end
			default: begin
				state_nxt = spi9_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spi9_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// half period counter, low half then high half per bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			phase_q <= 1'b0;
		end else if (in_acc) begin
			cnt_q   <= '0;
			phase_q <= 1'b0;
		end else if (state_q == spi9_pkg::ST_RUN) begin
			if (cnt_wrap) begin
				cnt_q   <= '0;
				phase_q <= !phase_q;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// word bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_idx_q    <= '0;
			words_left_q <= '0;
			is_data_q    <= 1'b0;
		end else if (in_acc) begin
			bit_idx_q    <= '0;
			words_left_q <= (data_count > 2'd2) ? 2'd2 : data_count;
			is_data_q    <= 1'b0;
		end else if (emit) begin
			if (last_bit) begin
				bit_idx_q <= '0;
				if (words_left_q != 2'd0) begin
					words_left_q <= words_left_q - 2'd1;
					is_data_q    <= 1'b1;
				end
			end else begin
				bit_idx_q <= bit_idx_q + 4'd1;
			end
		end
	end

	// shift register, msb first, reloaded at each word boundary
	always_ff @(posedge clk) begin
		if (in_acc) begin
			shift_q <= {spi9_pkg::CMD_FLAG, reg_addr};
			pend_q  <= (data_count >= 2'd2) ? data_value : {8'h00, data_value[7:0]};
		end else if (emit) begin
			if (last_bit) begin
				if (words_left_q == 2'd2) begin
					shift_q <= {spi9_pkg::DATA_FLAG, pend_q[15:8]};
					pend_q  <= {8'h00, pend_q[7:0]};
				end else begin
					shift_q <= {spi9_pkg::DATA_FLAG, pend_q[7:0]};
					pend_q  <= '0;
				end
			end else begin
				shift_q <= {shift_q[7:0], 1'b0};
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sda_q  <= shift_q[8];
			data_q <= is_data_q;
			last_q <= frame_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign sda_bit      = sda_q;
	assign word_is_data = data_q;
	assign frame_last   = last_q;

	`include "spi9_panel_register_writer_top_assert.svh"

	// a fresh word starts the command word at its first bit
	`SPI9_ASSERT_NEXT(a_start, in_acc, (state_q == spi9_pkg::ST_RUN) && (bit_idx_q == 4'd0) && !is_data_q, "frame start not set up")
	// bit counter never passes the word length
	`SPI9_ASSERT_NOW(a_bit_range, 1'b1, bit_idx_q <= spi9_pkg::LAST_BIT_IDX, "bit index out of range")
	// holding only happens behind a pending output word
	`SPI9_ASSERT_NOW(a_hold, state_q == spi9_pkg::ST_HOLD, out_valid_q, "hold without pending output")
	// an emitted frame end sends the block back to idle
	`SPI9_ASSERT_NEXT(a_end_idle, emit && frame_end, state_q == spi9_pkg::ST_IDLE, "frame end not idle")

endmodule
